// ===== rtl/core/morse_char_to_led_timing_defines.svh =====
// Assertion macros for the Morse keyer block.
// Used by the top level; relies on clk and rst_n being in scope where expanded.
`ifndef MORSE_CHAR_TO_LED_TIMING_DEFINES_SVH
`define MORSE_CHAR_TO_LED_TIMING_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define MCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MCT_ASSERT(label, prop, msg)
`define MCT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/core/mct_pkg.sv =====
// Shared types, constants, the Morse code table and the microprogram for the keyer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mct_pkg;

    // Field widths.
    localparam int CharWidth  = 8;
    localparam int EntryWidth = 6;
    localparam int DurWidth   = 3;
    localparam int LenWidth   = 3;
    localparam int PatWidth   = 6;
    localparam int PcWidth    = 3;

    // Table geometry and special entries.
    localparam logic [EntryWidth-1:0] TableSize   = 6'd40;
    localparam logic [EntryWidth-1:0] EntryEmpty  = 6'd0;
    localparam logic [EntryWidth-1:0] EntryComma  = 6'd37;
    localparam logic [EntryWidth-1:0] EntryPeriod = 6'd38;
    localparam logic [EntryWidth-1:0] EntryQuery  = 6'd39;

    // Character codes with a meaning of their own.
    localparam logic [CharWidth-1:0] CharNul    = 8'd0;
    localparam logic [CharWidth-1:0] CharSpace  = 8'd32;
    localparam logic [CharWidth-1:0] CharComma  = 8'd44;
    localparam logic [CharWidth-1:0] CharPeriod = 8'd46;
    localparam logic [CharWidth-1:0] CharQuery  = 8'd63;

    // Segment lengths in dot units.
    localparam logic [DurWidth-1:0] DotUnits   = 3'd1;
    localparam logic [DurWidth-1:0] DashUnits  = 3'd3;
    localparam logic [DurWidth-1:0] GapElement = 3'd1;
    localparam logic [DurWidth-1:0] GapLetter  = 3'd3;
    localparam logic [DurWidth-1:0] GapWord    = 3'd7;

    typedef logic [PcWidth-1:0] pc_t;

    // Microprogram step addresses.
    localparam pc_t PcIdle  = 3'd0;
    localparam pc_t PcNul   = 3'd1;
    localparam pc_t PcSpace = 3'd2;
    localparam pc_t PcEmpty = 3'd3;
    localparam pc_t PcMark  = 3'd4;
    localparam pc_t PcBreak = 3'd5;
    localparam pc_t PcLGap  = 3'd6;
    localparam pc_t PcWGap  = 3'd7;

    // Segment length selector.
    typedef enum logic [1:0] {
        DUR_ELEM,
        DUR_ONE,
        DUR_THREE,
        DUR_SEVEN
    } dur_sel_t;

    // Jump conditions: when true the step jumps to its target, else it falls through.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NSTART,
        C_ZERO,
        C_SPACE,
        C_EMPTY,
        C_MORE
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic     busy;
        logic     emit;
        logic     led_on;
        dur_sel_t dur_sel;
        logic     last;
        logic     advance;
        cond_t    cond;
        pc_t      target;
    } ctl_t;

    // Datapath status that the sequencer branches on.
    typedef struct packed {
        logic start;
        logic zero;
        logic space;
        logic empty;
        logic more;
    } stat_t;

    // Decoded request as loaded into the datapath.
    typedef struct packed {
        logic                zero;
        logic                space;
        logic [LenWidth-1:0] len;
        logic [PatWidth-1:0] pat;
    } sym_t;

    // Element count and pattern of one code (1 is dash, first element in bit len-1).
    typedef struct packed {
        logic [LenWidth-1:0] len;
        logic [PatWidth-1:0] bits;
    } code_t;

    function automatic code_t code_lookup(input logic [EntryWidth-1:0] entry);
        code_t c;
        case (entry)
            6'd1:    c = '{3'd2, 6'd1};
            6'd2:    c = '{3'd4, 6'd8};
            6'd3:    c = '{3'd4, 6'd10};
            6'd4:    c = '{3'd3, 6'd4};
            6'd5:    c = '{3'd1, 6'd0};
            6'd6:    c = '{3'd4, 6'd2};
            6'd7:    c = '{3'd3, 6'd6};
            6'd8:    c = '{3'd4, 6'd0};
            6'd9:    c = '{3'd2, 6'd0};
            6'd10:   c = '{3'd4, 6'd7};
            6'd11:   c = '{3'd3, 6'd5};
            6'd12:   c = '{3'd4, 6'd4};
            6'd13:   c = '{3'd2, 6'd3};
            6'd14:   c = '{3'd2, 6'd2};
            6'd15:   c = '{3'd3, 6'd7};
            6'd16:   c = '{3'd4, 6'd6};
            6'd17:   c = '{3'd4, 6'd13};
            6'd18:   c = '{3'd3, 6'd2};
            6'd19:   c = '{3'd3, 6'd0};
            6'd20:   c = '{3'd1, 6'd1};
            6'd21:   c = '{3'd3, 6'd1};
            6'd22:   c = '{3'd4, 6'd1};
            6'd23:   c = '{3'd3, 6'd3};
            6'd24:   c = '{3'd4, 6'd9};
            6'd25:   c = '{3'd4, 6'd11};
            6'd26:   c = '{3'd4, 6'd12};
            6'd27:   c = '{3'd5, 6'd31};
            6'd28:   c = '{3'd5, 6'd15};
            6'd29:   c = '{3'd5, 6'd7};
            6'd30:   c = '{3'd5, 6'd3};
            6'd31:   c = '{3'd5, 6'd1};
            6'd32:   c = '{3'd5, 6'd0};
            6'd33:   c = '{3'd5, 6'd16};
            6'd34:   c = '{3'd5, 6'd24};
            6'd35:   c = '{3'd5, 6'd28};
            6'd36:   c = '{3'd5, 6'd30};
            6'd37:   c = '{3'd6, 6'd51};
            6'd38:   c = '{3'd6, 6'd21};
            6'd39:   c = '{3'd6, 6'd12};
            default: c = '{3'd0, 6'd0};
        endcase
        return c;
    endfunction

    // Microprogram: one control word per step.
    function automatic ctl_t ucode(input pc_t pc);
        ctl_t w;
        unique case (pc)
            PcIdle:  w = '{1'b0, 1'b0, 1'b0, DUR_ONE,   1'b0, 1'b0, C_NSTART, PcIdle};
            PcNul:   w = '{1'b1, 1'b0, 1'b0, DUR_ONE,   1'b0, 1'b0, C_ZERO,   PcIdle};
            PcSpace: w = '{1'b1, 1'b0, 1'b0, DUR_ONE,   1'b0, 1'b0, C_SPACE,  PcWGap};
            PcEmpty: w = '{1'b1, 1'b0, 1'b0, DUR_ONE,   1'b0, 1'b0, C_EMPTY,  PcLGap};
            PcMark:  w = '{1'b1, 1'b1, 1'b1, DUR_ELEM,  1'b0, 1'b0, C_NEXT,   PcIdle};
            PcBreak: w = '{1'b1, 1'b1, 1'b0, DUR_ONE,   1'b0, 1'b1, C_MORE,   PcMark};
            PcLGap:  w = '{1'b1, 1'b1, 1'b0, DUR_THREE, 1'b1, 1'b0, C_ALWAYS, PcIdle};
            PcWGap:  w = '{1'b1, 1'b1, 1'b0, DUR_SEVEN, 1'b1, 1'b0, C_ALWAYS, PcIdle};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/morse_char_to_led_timing.sv =====
// Morse keyer: turns one ASCII byte per request into a run of LED on/off segments.
// Channels: a request is taken at a rising edge with start high and busy low;
// char_code is sampled then. Each segment appears on led_on, duration_units and
// last for exactly one cycle with result_valid high; last marks the final segment
// of the character. The receiver cannot hold results off.
// Configuration: wr_en with wr_data writes default_entry, the table entry used
// for bytes without a Morse code; write it only while busy is low.
// Timing: a microcoded sequencer walks three dispatch steps, then two steps per
// code element (mark and break), then one step for the letter gap. Busy stays high
// through all of these steps; the next request is taken at the earliest in the
// idle cycle after them. Segments are registered from the mark, break and gap steps,
// one segment every cycle with no gap between elements. A space keeps busy high
// through two dispatch steps and the word gap and gives one segment; a zero byte
// keeps it high only for the first dispatch step and gives none.
// Reset: default_entry returns to 0 (the empty entry) and the sequencer to idle.
// Depends on mct_pkg, mct_decode, mct_seq and morse_char_to_led_timing_defines.svh.
`timescale 1ns / 1ps

`include "morse_char_to_led_timing_defines.svh"

module morse_char_to_led_timing (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [mct_pkg::CharWidth-1:0]     char_code,
    input  logic                              wr_en,
    input  logic [mct_pkg::EntryWidth-1:0]    wr_data,
    output logic                              result_valid,
    output logic                              led_on,
    output logic [mct_pkg::DurWidth-1:0]      duration_units,
    output logic                              last
);

    logic [mct_pkg::EntryWidth-1:0] default_entry_reg;
    mct_pkg::sym_t                  sym;
    mct_pkg::stat_t                 stat;
    mct_pkg::ctl_t                  ctl;
    logic                           accept;

    logic                           zero_reg;
    logic                           space_reg;
    logic [mct_pkg::LenWidth-1:0]   rem_reg;
    logic [mct_pkg::PatWidth-1:0]   pat_reg;

    logic                           valid_reg;
    logic                           led_on_reg;
    logic [mct_pkg::DurWidth-1:0]   dur_reg;
    logic                           last_reg;
    logic [mct_pkg::DurWidth-1:0]   dur_next;
    logic                           mark_len_ok;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            default_entry_reg <= mct_pkg::EntryEmpty;
        else if (wr_en)
            default_entry_reg <= wr_data;
    end

    mct_decode u_decode (
        .char_code     (char_code),
        .default_entry (default_entry_reg),
        .sym           (sym)
    );

    mct_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    assign busy   = ctl.busy;
    assign accept = start && !ctl.busy;

    // Status for the sequencer's branches.
    assign stat.start = start;
    assign stat.zero  = zero_reg;
    assign stat.space = space_reg;
    assign stat.empty = (rem_reg == 3'd0);
    assign stat.more  = (rem_reg > 3'd1);

    // Request flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg  <= 1'b0;
            space_reg <= 1'b0;
        end
        else if (accept)
        begin
            zero_reg  <= sym.zero;
            space_reg <= sym.space;
        end
    end

    // Element counter and pattern shifter.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rem_reg <= sym.len;
            pat_reg <= sym.pat;
        end
        else if (ctl.advance)
        begin
            rem_reg <= rem_reg - 3'd1;
            pat_reg <= pat_reg << 1;
        end
    end

    // Segment length for the current step.
    always_comb
    begin
        unique case (ctl.dur_sel)
            mct_pkg::DUR_ELEM:
                dur_next = pat_reg[mct_pkg::PatWidth-1] ? mct_pkg::DashUnits : mct_pkg::DotUnits;
            mct_pkg::DUR_ONE:   dur_next = mct_pkg::GapElement;
            mct_pkg::DUR_THREE: dur_next = mct_pkg::GapLetter;
            mct_pkg::DUR_SEVEN: dur_next = mct_pkg::GapWord;
            default:            dur_next = mct_pkg::GapElement;
        endcase
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ctl.emit;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        led_on_reg <= ctl.led_on;
        dur_reg    <= dur_next;
        last_reg   <= ctl.last;
    end

    assign result_valid   = valid_reg;
    assign led_on         = led_on_reg;
    assign duration_units = dur_reg;
    assign last           = last_reg;

    // A lit segment can only be a dot or a dash.
    assign mark_len_ok = (duration_units == mct_pkg::DotUnits)
                      || (duration_units == mct_pkg::DashUnits);

    // The final segment of a character is shown once the sequencer is idle again.
    `MCT_ASSERT(a_last_idle, (result_valid && last) |-> !busy, "final segment while still busy")

    // Nothing is shown in the cycle after a request is taken.
    `MCT_ASSERT(a_quiet_after_req, (start && !busy) |=> !result_valid, "segment right after request")

    // Lit segments are always a dot or a dash.
    `MCT_ASSERT(a_mark_len, (result_valid && led_on) |-> mark_len_ok, "bad mark length")

    // The block is idle while reset is applied.
    `MCT_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!busy && !result_valid), "busy during reset")

endmodule

// ===== rtl/core/mct_decode.sv =====
// Character decoder: maps an ASCII byte to its Morse table entry and element pattern.
// Depends on mct_pkg for the code table and the sym_t type.
`timescale 1ns / 1ps

module mct_decode (
    input  logic [mct_pkg::CharWidth-1:0]  char_code,
    input  logic [mct_pkg::EntryWidth-1:0] default_entry,
    output mct_pkg::sym_t                  sym
);

    logic [mct_pkg::EntryWidth-1:0] dflt;
    logic [mct_pkg::EntryWidth-1:0] entry;
    logic [mct_pkg::CharWidth-1:0]  lower_off;
    logic [mct_pkg::CharWidth-1:0]  upper_off;
    logic [mct_pkg::CharWidth-1:0]  digit_off;
    mct_pkg::code_t                 code;
    logic [mct_pkg::LenWidth-1:0]   shamt;

    // Out-of-range defaults fall back to the empty entry.
    assign dflt = (default_entry < mct_pkg::TableSize) ? default_entry : mct_pkg::EntryEmpty;

    assign lower_off = char_code - 8'd96;
    assign upper_off = char_code - 8'd64;
    assign digit_off = char_code - 8'd21;

    // Range checks on the byte, highest range first.
    always_comb
    begin
        if (char_code > 8'd122)
            entry = dflt;
        else if (char_code > 8'd96)
            entry = lower_off[mct_pkg::EntryWidth-1:0];
        else if (char_code > 8'd90)
            entry = dflt;
        else if (char_code > 8'd64)
            entry = upper_off[mct_pkg::EntryWidth-1:0];
        else if (char_code == mct_pkg::CharQuery)
            entry = mct_pkg::EntryQuery;
        else if (char_code > 8'd57)
            entry = dflt;
        else if (char_code > 8'd47)
            entry = digit_off[mct_pkg::EntryWidth-1:0];
        else if (char_code == mct_pkg::CharPeriod)
            entry = mct_pkg::EntryPeriod;
        else if (char_code == mct_pkg::CharComma)
            entry = mct_pkg::EntryComma;
        else
            entry = dflt;
    end

    assign code = mct_pkg::code_lookup(entry);

    // Align the pattern so that the first element sits in the top bit.
    assign shamt = 3'(mct_pkg::PatWidth) - code.len;

    assign sym.zero  = (char_code == mct_pkg::CharNul);
    assign sym.space = (char_code == mct_pkg::CharSpace);
    assign sym.len   = code.len;
    assign sym.pat   = code.bits << shamt;

endmodule

// ===== rtl/core/mct_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jump logic.
// Depends on mct_pkg for the control word, status struct and microprogram.
`timescale 1ns / 1ps

module mct_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  mct_pkg::stat_t stat,
    output mct_pkg::ctl_t  ctl
);

    mct_pkg::pc_t pc_reg;
    mct_pkg::pc_t pc_next;
    logic         take;

    // Current control word straight from the control store.
    assign ctl = mct_pkg::ucode(pc_reg);

    // Evaluate the jump condition of the current step.
    always_comb
    begin
        unique case (ctl.cond)
            mct_pkg::C_NEXT:   take = 1'b0;
            mct_pkg::C_ALWAYS: take = 1'b1;
            mct_pkg::C_NSTART: take = !stat.start;
            mct_pkg::C_ZERO:   take = stat.zero;
            mct_pkg::C_SPACE:  take = stat.space;
            mct_pkg::C_EMPTY:  take = stat.empty;
            mct_pkg::C_MORE:   take = stat.more;
            default:           take = 1'b0;
        endcase
    end

    assign pc_next = take ? ctl.target : pc_reg + 3'd1;

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= mct_pkg::PcIdle;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== dv/morse_char_to_led_timing_tb.sv =====
// Self-checking testbench for the Morse keyer: directed table, then random characters.
// Predicts segments from its own code table or typed rows; depends on mct_pkg and the RTL.
`timescale 1ns / 1ps

module morse_char_to_led_timing_tb;

    // One LED segment as it appears on the result ports.
    typedef struct packed {
        logic                         led_on;
        logic [mct_pkg::DurWidth-1:0] dur;
        logic                         last;
    } segment_t;

    typedef enum logic {
        ROW_CHAR,
        ROW_CONFIG
    } row_kind_t;

    // One row of the directed table; segs is used only when typed is set.
    typedef struct packed {
        row_kind_t                     kind;
        logic                          typed;
        logic [1:0]                    n_segs;
        logic [mct_pkg::CharWidth-1:0] value;
        segment_t [0:2]                segs;
    } stim_row_t;

    localparam segment_t SegNone   = '0;
    localparam segment_t SegDot    = {1'b1, mct_pkg::DotUnits, 1'b0};
    localparam segment_t SegDash   = {1'b1, mct_pkg::DashUnits, 1'b0};
    localparam segment_t SegBreak  = {1'b0, mct_pkg::GapElement, 1'b0};
    localparam segment_t SegLetter = {1'b0, mct_pkg::GapLetter, 1'b1};
    localparam segment_t SegWord   = {1'b0, mct_pkg::GapWord, 1'b1};

    // Character ranges of the code table.
    localparam logic [mct_pkg::CharWidth-1:0] UpperA = 8'h41;
    localparam logic [mct_pkg::CharWidth-1:0] UpperZ = 8'h5A;
    localparam logic [mct_pkg::CharWidth-1:0] LowerA = 8'h61;
    localparam logic [mct_pkg::CharWidth-1:0] LowerZ = 8'h7A;
    localparam logic [mct_pkg::CharWidth-1:0] Digit0 = 8'h30;
    localparam logic [mct_pkg::CharWidth-1:0] Digit9 = 8'h39;
    localparam int FirstLetterEntry = 1;
    localparam int FirstDigitEntry  = 27;

    localparam int NumDirected   = 30;
    localparam int NumPhases     = 6;
    localparam int ItemsPerPhase = 50;
    localparam int SettleCycles  = 20;
    localparam int WatchdogLimit = 1000;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [mct_pkg::CharWidth-1:0]  char_code;
    logic                           wr_en;
    logic [mct_pkg::EntryWidth-1:0] wr_data;
    logic                           result_valid;
    logic                           led_on;
    logic [mct_pkg::DurWidth-1:0]   duration_units;
    logic                           last;

    segment_t                       segments_due[$];
    logic [mct_pkg::EntryWidth-1:0] fallback_entry;
    int                             fail_count  = 0;
    int                             idle_cycles = 0;

    // Directed table: empty entry, zero byte, space, table edges, fallback settings.
    stim_row_t directed_rows [NumDirected] = '{
        {ROW_CHAR,   1'b1, 2'd1, 8'd35,               SegLetter, SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd0, mct_pkg::CharNul,    SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd1, mct_pkg::CharSpace,  SegWord,   SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd3, 8'd69,               SegDot,    SegBreak, SegLetter},
        {ROW_CHAR,   1'b1, 2'd3, 8'd116,              SegDash,   SegBreak, SegLetter},
        {ROW_CHAR,   1'b0, 2'd0, UpperA,              SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, UpperZ,              SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, LowerA,              SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, LowerZ,              SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, Digit0,              SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, Digit9,              SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, mct_pkg::CharComma,  SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, mct_pkg::CharPeriod, SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, mct_pkg::CharQuery,  SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, 8'd81,               SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd1, 8'd255,              SegLetter, SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd1, 8'd64,               SegLetter, SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd1, 8'd47,               SegLetter, SegNone,  SegNone},
        {ROW_CONFIG, 1'b0, 2'd0, 8'd39,               SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, 8'd255,              SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, 8'd91,               SegNone,   SegNone,  SegNone},
        {ROW_CONFIG, 1'b0, 2'd0, 8'd63,               SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd1, 8'd128,              SegLetter, SegNone,  SegNone},
        {ROW_CONFIG, 1'b0, 2'd0, 8'd40,               SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd1, 8'd96,               SegLetter, SegNone,  SegNone},
        {ROW_CONFIG, 1'b0, 2'd0, 8'd5,                SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, 8'd58,               SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b0, 2'd0, 8'd123,              SegNone,   SegNone,  SegNone},
        {ROW_CONFIG, 1'b0, 2'd0, 8'd0,                SegNone,   SegNone,  SegNone},
        {ROW_CHAR,   1'b1, 2'd1, 8'd62,               SegLetter, SegNone,  SegNone}
    };

    morse_char_to_led_timing u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .char_code      (char_code),
        .wr_en          (wr_en),
        .wr_data        (wr_data),
        .result_valid   (result_valid),
        .led_on         (led_on),
        .duration_units (duration_units),
        .last           (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Dots and dashes of each table entry, written out as text.
    function automatic string code_pattern(input int entry);
        case (entry)
            1:  return ".-";
            2:  return "-...";
            3:  return "-.-.";
            4:  return "-..";
            5:  return ".";
            6:  return "..-.";
            7:  return "--.";
            8:  return "....";
            9:  return "..";
            10: return ".---";
            11: return "-.-";
            12: return ".-..";
            13: return "--";
            14: return "-.";
            15: return "---";
            16: return ".--.";
            17: return "--.-";
            18: return ".-.";
            19: return "...";
            20: return "-";
            21: return "..-";
            22: return "...-";
            23: return ".--";
            24: return "-..-";
            25: return "-.--";
            26: return "--..";
            27: return "-----";
            28: return ".----";
            29: return "..---";
            30: return "...--";
            31: return "....-";
            32: return ".....";
            33: return "-....";
            34: return "--...";
            35: return "---..";
            36: return "----.";
            37: return "--..--";
            38: return ".-.-.-";
            39: return "..--..";
            default: return "";
        endcase
    endfunction

    // Table entry for a byte; anything without a code falls back to the register.
    function automatic int entry_for(input logic [mct_pkg::CharWidth-1:0] c);
        int fallback;
        fallback = (fallback_entry < mct_pkg::TableSize) ? int'(fallback_entry)
                                                         : int'(mct_pkg::EntryEmpty);
        if (c >= LowerA && c <= LowerZ)
            return int'(c - LowerA) + FirstLetterEntry;
        if (c >= UpperA && c <= UpperZ)
            return int'(c - UpperA) + FirstLetterEntry;
        if (c >= Digit0 && c <= Digit9)
            return int'(c - Digit0) + FirstDigitEntry;
        if (c == mct_pkg::CharQuery)
            return int'(mct_pkg::EntryQuery);
        if (c == mct_pkg::CharPeriod)
            return int'(mct_pkg::EntryPeriod);
        if (c == mct_pkg::CharComma)
            return int'(mct_pkg::EntryComma);
        return fallback;
    endfunction

    // Queues the segments that one character should produce.
    function automatic void predict_segments(input logic [mct_pkg::CharWidth-1:0] c);
        string pattern;
        if (c == mct_pkg::CharNul)
            return;
        if (c == mct_pkg::CharSpace)
        begin
            segments_due.push_back(SegWord);
            return;
        end
        pattern = code_pattern(entry_for(c));
        for (int i = 0; i < pattern.len(); i++)
        begin
            segments_due.push_back((pattern[i] == "-") ? SegDash : SegDot);
            segments_due.push_back(SegBreak);
        end
        segments_due.push_back(SegLetter);
    endfunction

    // Mostly characters with a code, with spaces, zero bytes and arbitrary bytes mixed in.
    function automatic logic [mct_pkg::CharWidth-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            case ($urandom_range(0, 3))
                0: return UpperA + 8'($urandom_range(0, 25));
                1: return LowerA + 8'($urandom_range(0, 25));
                2: return Digit0 + 8'($urandom_range(0, 9));
                default:
                    case ($urandom_range(0, 2))
                        0: return mct_pkg::CharComma;
                        1: return mct_pkg::CharPeriod;
                        default: return mct_pkg::CharQuery;
                    endcase
            endcase
        end
        if (roll < 67)
            return mct_pkg::CharSpace;
        if (roll < 72)
            return mct_pkg::CharNul;
        return 8'($urandom);
    endfunction

    // Presents one request and returns at the edge that takes it.
    task automatic send_char(input logic [mct_pkg::CharWidth-1:0] c);
        @(negedge clk);
        start     = 1'b1;
        char_code = c;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start     = 1'b0;
            char_code = 8'($urandom);
        end
    endtask

    // Holds off until every predicted segment has arrived and the sequencer has settled.
    task automatic drain_segments();
        @(negedge clk);
        start = 1'b0;
        while (segments_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles)
            @(posedge clk);
    endtask

    task automatic write_fallback(input logic [mct_pkg::EntryWidth-1:0] value);
        @(negedge clk);
        wr_en   = 1'b1;
        wr_data = value;
        @(negedge clk);
        wr_en          = 1'b0;
        wr_data        = 6'($urandom);
        fallback_entry = value;
    endtask

    // Compares each segment with the oldest prediction.
    always @(posedge clk)
    begin : segment_check
        segment_t want;
        if (rst_n && result_valid)
        begin
            if (segments_due.size() == 0)
            begin
                $error("segment with none predicted: led_on %0d duration_units %0d last %0d",
                       led_on, duration_units, last);
                fail_count++;
            end
            else
            begin
                want = segments_due.pop_front();
                if (led_on !== want.led_on)
                begin
                    $error("led_on: expected %0d, got %0d", want.led_on, led_on);
                    fail_count++;
                end
                if (duration_units !== want.dur)
                begin
                    $error("duration_units: expected %0d, got %0d", want.dur, duration_units);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither a request nor a segment is taken for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t                     row;
        int                            idle_pct;
        logic [mct_pkg::CharWidth-1:0] c;

        rst_n          = 1'b0;
        start          = 1'b0;
        char_code      = '0;
        wr_en          = 1'b0;
        wr_data        = '0;
        fallback_entry = mct_pkg::EntryEmpty;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed part: typed rows carry their segments, the others use the predictor.
        for (int r = 0; r < NumDirected; r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CONFIG)
            begin
                drain_segments();
                write_fallback(row.value[mct_pkg::EntryWidth-1:0]);
            end
            else
            begin
                send_char(row.value);
                if (row.typed)
                begin
                    for (int k = 0; k < row.n_segs; k++)
                        segments_due.push_back(row.segs[k]);
                end
                else
                    predict_segments(row.value);
            end
        end

        // Random part: a new fallback per phase, idling density varying by phase,
        // and none at all in the final phase.
        for (int phase = 0; phase < NumPhases; phase++)
        begin
            drain_segments();
            write_fallback(6'($urandom));
            idle_pct = (phase == NumPhases - 1) ? 0 : (phase % 3) * 30;
            for (int i = 0; i < ItemsPerPhase; i++)
            begin
                if (phase == 1 && i == ItemsPerPhase / 2)
                    drain_segments();
                if ($urandom_range(0, 99) < idle_pct)
                    idle_for($urandom_range(1, 11));
                c = pick_char();
                send_char(c);
                predict_segments(c);
            end
        end

        drain_segments();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mct_pkg.sv
rtl/core/mct_decode.sv
rtl/core/mct_seq.sv
rtl/core/morse_char_to_led_timing.sv
dv/morse_char_to_led_timing_tb.sv
